// File: hw/rtl/fqpd_pkg.sv
`default_nettype none

package fqpd_pkg;

    localparam int FQPD_DEPTH = 16;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 16;
    localparam int OCC_W      = 5;

    localparam logic signed [WORD_W-1:0] POP_EMPTY_WORD = -32'sd1;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_DELETE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [WORD_W-1:0]  push_value;
        logic [POS_W-1:0]          delete_position;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0]  popped_value;
        t_status                   status;
        logic                      is_empty;
        logic [OCC_W-1:0]          occupancy;
    } t_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/fqpd_cmd_if.sv
`default_nettype none

interface fqpd_cmd_if
    import fqpd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_opcode                  opcode;
    logic signed [WORD_W-1:0] push_value;
    logic [POS_W-1:0]         delete_position;

    modport source (output valid, opcode, push_value, delete_position, input ready);
    modport sink   (input valid, opcode, push_value, delete_position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fqpd_rsp_if.sv
`default_nettype none

interface fqpd_rsp_if
    import fqpd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] popped_value;
    t_status                  status;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, popped_value, status, is_empty, occupancy, input ready);
    modport sink   (input valid, popped_value, status, is_empty, occupancy, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fqpd_core.sv
`default_nettype none

module fqpd_core
    import fqpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = FQPD_DEPTH
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_en,
    input  t_cmd i_cmd,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic signed [WORD_W-1:0] r_slots [QUEUE_DEPTH];
    logic signed [WORD_W-1:0] w_next  [QUEUE_DEPTH];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     w_shift;
    logic                     w_push;
    logic [IW-1:0]            w_idx;
    logic [IW-1:0]            w_push_idx;
    logic signed [WORD_W-1:0] w_popped;
    t_status                  w_status;

    assign w_push_idx = IW'(r_count);

    always_comb begin
        n_count  = r_count;
        w_shift  = 1'b0;
        w_push   = 1'b0;
        w_idx    = '0;
        w_popped = '0;
        w_status = ST_OK;
        unique case (i_cmd.opcode)
            OP_PUSH: begin
                if (r_count < CW'(QUEUE_DEPTH)) begin
                    w_push  = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    w_status = ST_FULL;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    w_popped = POP_EMPTY_WORD;
                    w_status = ST_EMPTY;
                end else begin
                    w_popped = r_slots[0];
                    w_shift  = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_DELETE: begin
                if (i_cmd.delete_position == '0 ||
                    32'(i_cmd.delete_position) > 32'(r_count)) begin
                    w_status = ST_MISSING;
                end else begin
                    w_shift = 1'b1;
                    w_idx   = IW'(i_cmd.delete_position - POS_W'(1));
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        o_rsp.popped_value = w_popped;
        o_rsp.status       = w_status;
        o_rsp.is_empty     = (n_count == '0);
        o_rsp.occupancy    = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        if (k < QUEUE_DEPTH - 1) begin : g_link
            assign w_next[k] = r_slots[k+1];
        end else begin : g_last
            assign w_next[k] = r_slots[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_push && w_push_idx == IW'(k)) begin
                    r_slots[k] <= i_cmd.push_value;
                end else if (w_shift && IW'(k) >= w_idx) begin
                    r_slots[k] <= w_next[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fifo_queue_with_positional_delete.sv
`default_nettype none

// Bounded FIFO of signed 32-bit words held in a row of QUEUE_DEPTH shift cells, head in
// cell 0. Each command word (push, pop, clear, delete at a one-based position) yields
// exactly one response word carrying the popped word (-1 on a pop of an empty queue,
// zero on any command that is not a pop), a status (ok, pop on empty, push on full,
// position missing), an empty flag and the low 5 bits of the count after the command.
// A pop or delete closes the gap by shifting the later cells down. Commands are
// registered, executed against the cells and the response is registered, so the block
// takes one command per cycle while the response output is not stalled. Each command
// passes the command register and then the response register, and its response word is
// held until the output takes it. The cells need no clearing after reset.

module fifo_queue_with_positional_delete
    import fqpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = FQPD_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fqpd_cmd_if.sink   i_cmd,
    fqpd_rsp_if.source o_rsp
);

    logic r_cmd_valid;
    t_cmd r_cmd;
    logic r_rsp_valid;
    t_rsp r_rsp;
    t_rsp w_rsp;
    logic w_exec;

    assign w_exec      = r_cmd_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_cmd.ready = !r_cmd_valid || w_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd.opcode          <= i_cmd.opcode;
            r_cmd.push_value      <= i_cmd.push_value;
            r_cmd.delete_position <= i_cmd.delete_position;
        end
    end

    fqpd_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_exec),
        .i_cmd   (r_cmd),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_exec) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.popped_value = r_rsp.popped_value;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.is_empty     = r_rsp.is_empty;
    assign o_rsp.occupancy    = r_rsp.occupancy;

endmodule

`default_nettype wire

// File: sim/tb_fifo_queue_with_positional_delete.sv
`default_nettype none

module tb_fifo_queue_with_positional_delete;
    import fqpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fqpd_cmd_if cmd_if ();
    fqpd_rsp_if rsp_if ();

    fifo_queue_with_positional_delete u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic signed [WORD_W-1:0] model_q[$];
    t_rsp                     expected_rsps[$];

    int  err_count     = 0;
    int  op_seen[4]    = '{0, 0, 0, 0};
    int  status_seen[4] = '{0, 0, 0, 0};
    int  full_hits     = 0;
    int  hold_request  = 0;
    bit  tx_idle       = 1'b1;
    bit  rx_idle       = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // queue model: applies one command and returns the word it must produce
    function automatic t_rsp queue_model_step(t_opcode op, logic signed [WORD_W-1:0] val,
                                              logic [POS_W-1:0] pos);
        t_rsp rsp;
        rsp.popped_value = '0;
        rsp.status       = ST_OK;
        case (op)
            OP_PUSH: begin
                if (model_q.size() < FQPD_DEPTH) begin
                    model_q.push_back(val);
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            OP_POP: begin
                if (model_q.size() == 0) begin
                    rsp.popped_value = POP_EMPTY_WORD;
                    rsp.status       = ST_EMPTY;
                end else begin
                    rsp.popped_value = model_q.pop_front();
                end
            end
            OP_CLEAR: begin
                model_q.delete();
            end
            default: begin
                if (pos == '0 || int'(pos) > model_q.size()) begin
                    rsp.status = ST_MISSING;
                end else begin
                    model_q.delete(int'(pos) - 1);
                end
            end
        endcase
        rsp.is_empty  = (model_q.size() == 0);
        rsp.occupancy = OCC_W'(model_q.size());
        return rsp;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(t_opcode op, logic signed [WORD_W-1:0] val, logic [POS_W-1:0] pos);
        t_rsp want;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        cmd_if.valid           = 1'b1;
        cmd_if.opcode          = op;
        cmd_if.push_value      = val;
        cmd_if.delete_position = pos;
        do begin
            @(posedge i_clk);
        end while (cmd_if.ready !== 1'b1);
        if (op == OP_PUSH && model_q.size() == FQPD_DEPTH) begin
            full_hits++;
        end
        want = queue_model_step(op, val, pos);
        op_seen[op]++;
        status_seen[want.status]++;
        expected_rsps.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic send_random_cmd(t_mix mix);
        int unsigned              r;
        int unsigned              cnt;
        t_opcode                  op;
        logic signed [WORD_W-1:0] val;
        logic [POS_W-1:0]         pos;
        r   = $urandom_range(0, 99);
        cnt = model_q.size();
        case (mix)
            MIX_FILL: begin
                op = (r < 70) ? OP_PUSH : (r < 85) ? OP_POP : (r < 98) ? OP_DELETE : OP_CLEAR;
            end
            MIX_DRAIN: begin
                op = (r < 25) ? OP_PUSH : (r < 65) ? OP_POP : (r < 98) ? OP_DELETE : OP_CLEAR;
            end
            default: begin
                op = (r < 45) ? OP_PUSH : (r < 75) ? OP_POP : (r < 98) ? OP_DELETE : OP_CLEAR;
            end
        endcase
        case ($urandom_range(0, 11))
            0:       val = {1'b1, {(WORD_W-1){1'b0}}};
            1:       val = {1'b0, {(WORD_W-1){1'b1}}};
            2:       val = '1;
            3:       val = '0;
            default: val = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < 70) begin
            pos = POS_W'($urandom_range(1, (cnt == 0) ? 1 : cnt));
        end else if (r < 80) begin
            pos = POS_W'(cnt + 1);
        end else if (r < 86) begin
            pos = '0;
        end else if (r < 90) begin
            pos = '1;
        end else begin
            pos = POS_W'($urandom_range(0, 65535));
        end
        send_cmd(op, val, pos);
    endtask

    task automatic wait_for_responses();
        cmd_if.valid = 1'b0;
        while (expected_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_directed();
        logic signed [WORD_W-1:0] val;
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_DELETE, '0, '0);
        send_cmd(OP_DELETE, '0, POS_W'(1));
        for (int i = 0; i < FQPD_DEPTH; i++) begin
            case (i)
                0:       val = {1'b1, {(WORD_W-1){1'b0}}};
                1:       val = {1'b0, {(WORD_W-1){1'b1}}};
                2:       val = '0;
                3:       val = '1;
                default: val = $urandom;
            endcase
            send_cmd(OP_PUSH, val, '0);
        end
        send_cmd(OP_PUSH, 32'sh5a5a_a5a5, '0);
        send_cmd(OP_DELETE, '0, '0);
        send_cmd(OP_DELETE, '0, POS_W'(FQPD_DEPTH + 1));
        send_cmd(OP_DELETE, '0, POS_W'(FQPD_DEPTH));
        send_cmd(OP_DELETE, '0, POS_W'(1));
        send_cmd(OP_DELETE, '0, POS_W'(7));
        send_cmd(OP_DELETE, '0, '1);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_CLEAR, '1, '1);
        send_cmd(OP_POP, '0, '0);
        wait_for_responses();
    endtask

    task automatic test_random_traffic(int n_items);
        t_mix mix;
        int   left;
        mix  = MIX_BALANCED;
        left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0) begin
                case ($urandom_range(0, 2))
                    0:       mix = MIX_FILL;
                    1:       mix = MIX_DRAIN;
                    default: mix = MIX_BALANCED;
                endcase
                left = $urandom_range(20, 60);
            end
            left--;
            send_random_cmd(mix);
        end
    endtask

    task automatic test_backpressure();
        tx_idle      = 1'b0;
        hold_request = 120;
        for (int i = 0; i < 60; i++) begin
            send_random_cmd(MIX_FILL);
        end
        tx_idle = 1'b1;
        wait_for_responses();
    endtask

    task automatic test_no_idle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(320);
    endtask

    // response side: random stall bursts and an occasional long hold-off
    initial begin
        int n;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                n            = hold_request;
                hold_request = 0;
                rsp_if.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : p_check
        t_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                $error("response word with none expected: popped_value %0d", rsp_if.popped_value);
                err_count++;
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_if.popped_value !== want.popped_value) begin
                    $error("popped_value mismatch: expected %0d, actual %0d",
                           want.popped_value, rsp_if.popped_value);
                    err_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_if.status);
                    err_count++;
                end
                if (rsp_if.is_empty !== want.is_empty) begin
                    $error("is_empty mismatch: expected %0d, actual %0d",
                           want.is_empty, rsp_if.is_empty);
                    err_count++;
                end
                if (rsp_if.occupancy !== want.occupancy) begin
                    $error("occupancy mismatch: expected %0d, actual %0d",
                           want.occupancy, rsp_if.occupancy);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n                = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.opcode          = OP_PUSH;
        cmd_if.push_value      = '0;
        cmd_if.delete_position = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(1400);
        test_backpressure();
        test_no_idle();

        cmd_if.valid = 1'b0;
        wait_for_responses();
        repeat (10) @(negedge i_clk);
        if (expected_rsps.size() != 0) begin
            $error("%0d response words never arrived", expected_rsps.size());
            err_count++;
        end

        $display("commands: %0d push, %0d pop, %0d clear, %0d delete; pushes on full %0d",
                 op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_CLEAR], op_seen[OP_DELETE],
                 full_hits);
        $display("statuses: ok %0d, pop on empty %0d, push on full %0d, position missing %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_MISSING]);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
